FILE: src/divide_modulo_64bit_assert.svh
// ----------------------------------------------------------------------------
// divide_modulo_64bit assertion macros
// concurrent assertion forms for the divider's output block
// ----------------------------------------------------------------------------
`ifndef DIVIDE_MODULO_64BIT_ASSERT_SVH
`define DIVIDE_MODULO_64BIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define DM64_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define DM64_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/dm64_pkg.sv
// ----------------------------------------------------------------------------
// dm64_pkg
// types and constants shared by the 64-bit divide / modulo blocks
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dm64_pkg;

   localparam int unsigned DATA_W = 64;
   localparam int unsigned FUNC_W = 2;

   localparam logic [FUNC_W-1:0] FUNC_SQUO = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_SREM = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_UQUO = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_UREM = 2'd3;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [DATA_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
   } req_payload_type;

   typedef struct packed {
      logic [DATA_W-1:0] result;
      logic              divide_by_zero;
   } rsp_payload_type;

   // one restoring step's worth of state
   typedef struct packed {
      logic              valid;
      logic              want_rem;
      logic              negate;
      logic              div_zero;
      logic [DATA_W-1:0] rem;
      logic [DATA_W-1:0] nq;
      logic [DATA_W-1:0] dvsr;
   } cell_type;

endpackage

FILE: src/dm64_pre.sv
// ----------------------------------------------------------------------------
// dm64_pre
// input stage: takes operand magnitudes and works out result sign
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dm64_pre (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     req_valid,
   input  dm64_pkg::req_payload_type req_payload,
   output dm64_pkg::cell_type       out_cell
);

   dm64_pkg::cell_type cell_ff;
   dm64_pkg::cell_type cell_in;

   logic                          is_signed;
   logic                          a_neg;
   logic                          b_neg;
   logic [dm64_pkg::DATA_W-1:0]   a_mag;
   logic [dm64_pkg::DATA_W-1:0]   b_mag;

   always_comb begin
      is_signed = (req_payload.func == dm64_pkg::FUNC_SQUO) ||
                  (req_payload.func == dm64_pkg::FUNC_SREM);
      a_neg = is_signed & req_payload.dividend[dm64_pkg::DATA_W-1];
      b_neg = is_signed & req_payload.divisor[dm64_pkg::DATA_W-1];
      a_mag = a_neg ? ('0 - req_payload.dividend) : req_payload.dividend;
      b_mag = b_neg ? ('0 - req_payload.divisor) : req_payload.divisor;

      cell_in.valid    = req_valid;
      cell_in.want_rem = (req_payload.func == dm64_pkg::FUNC_SREM) ||
                         (req_payload.func == dm64_pkg::FUNC_UREM);
      unique case (req_payload.func)
         dm64_pkg::FUNC_SQUO: cell_in.negate = a_neg ^ b_neg;
         dm64_pkg::FUNC_SREM: cell_in.negate = a_neg;
         default:             cell_in.negate = 1'b0;
      endcase
      cell_in.div_zero = (req_payload.divisor == '0);
      cell_in.rem      = '0;
      cell_in.nq       = a_mag;
      cell_in.dvsr     = b_mag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (advance) begin
         cell_ff.valid <= cell_in.valid;
      end
      if (advance) begin
         cell_ff.want_rem <= cell_in.want_rem;
         cell_ff.negate   <= cell_in.negate;
         cell_ff.div_zero <= cell_in.div_zero;
         cell_ff.rem      <= cell_in.rem;
         cell_ff.nq       <= cell_in.nq;
         cell_ff.dvsr     <= cell_in.dvsr;
      end
   end

   assign out_cell = cell_ff;

endmodule

FILE: src/dm64_cell.sv
// ----------------------------------------------------------------------------
// dm64_cell
// one restoring shift-subtract step, registered
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dm64_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  dm64_pkg::cell_type in_cell,
   output dm64_pkg::cell_type out_cell
);

   dm64_pkg::cell_type cell_ff;
   dm64_pkg::cell_type cell_in;

   logic                          carry;
   logic [dm64_pkg::DATA_W-1:0]   shifted;
   logic [dm64_pkg::DATA_W:0]     diff;
   logic                          take;

   always_comb begin
      carry   = in_cell.rem[dm64_pkg::DATA_W-1];
      shifted = {in_cell.rem[dm64_pkg::DATA_W-2:0], in_cell.nq[dm64_pkg::DATA_W-1]};
      diff    = {1'b0, shifted} - {1'b0, in_cell.dvsr};
      take    = carry | ~diff[dm64_pkg::DATA_W];

      cell_in      = in_cell;
      cell_in.rem  = take ? diff[dm64_pkg::DATA_W-1:0] : shifted;
      cell_in.nq   = {in_cell.nq[dm64_pkg::DATA_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (advance) begin
         cell_ff.valid <= cell_in.valid;
      end
      if (advance) begin
         cell_ff.want_rem <= cell_in.want_rem;
         cell_ff.negate   <= cell_in.negate;
         cell_ff.div_zero <= cell_in.div_zero;
         cell_ff.rem      <= cell_in.rem;
         cell_ff.nq       <= cell_in.nq;
         cell_ff.dvsr     <= cell_in.dvsr;
      end
   end

   assign out_cell = cell_ff;

endmodule

FILE: src/dm64_out.sv
// ----------------------------------------------------------------------------
// dm64_out
// result fixup, output register and skid stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "divide_modulo_64bit_assert.svh"

module dm64_out (
   input  logic                      clock,
   input  logic                      reset,
   input  dm64_pkg::cell_type        last_cell,
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output dm64_pkg::rsp_payload_type rsp_payload,
   output logic                      skid_full
);

   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   dm64_pkg::rsp_payload_type rsp_data_ff;
   dm64_pkg::rsp_payload_type rsp_data_in;
   logic                      skid_valid_ff;
   logic                      skid_valid_in;
   dm64_pkg::rsp_payload_type skid_data_ff;
   dm64_pkg::rsp_payload_type skid_data_in;

   logic                        out_free;
   logic [dm64_pkg::DATA_W-1:0] raw;
   dm64_pkg::rsp_payload_type   fixed;

   always_comb begin
      raw = last_cell.want_rem ? last_cell.rem : last_cell.nq;
      if (last_cell.div_zero) begin
         fixed.result = '0;
      end else if (last_cell.negate) begin
         fixed.result = '0 - raw;
      end else begin
         fixed.result = raw;
      end
      fixed.divide_by_zero = last_cell.div_zero;
   end

   always_comb begin
      out_free      = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         // pipeline frozen, drain the skid first
         if (out_free) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (last_cell.valid) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = fixed;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = fixed;
         end
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;
   assign skid_full   = skid_valid_ff;

   `DM64_ASSERT_NOW(a_skid_needs_out, clock, reset, skid_valid_ff, rsp_valid_ff, "skid holds a transaction while output register is empty")
   `DM64_ASSERT_NOW(a_dz_zero, clock, reset, rsp_valid_ff && rsp_data_ff.divide_by_zero, rsp_data_ff.result == '0, "divide by zero with nonzero result")
   `DM64_ASSERT_NEXT(a_skid_drains, clock, reset, skid_valid_ff && !rsp_stall, !skid_valid_ff, "skid did not drain when output was taken")

endmodule

FILE: src/divide_modulo_64bit.sv
// ----------------------------------------------------------------------------
// divide_modulo_64bit
// path: transaction accept to result valid runs through 1 input stage,
//    64 restoring step cells and 1 output register
// throughput: one transaction per cycle from the fully pipelined cell row, stalled while skid is full
// reset: synchronous, clears all stage valid bits; no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module divide_modulo_64bit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  dm64_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output dm64_pkg::rsp_payload_type rsp_payload
);

   dm64_pkg::cell_type stage [0:dm64_pkg::DATA_W];
   logic               skid_full;
   logic               advance;

   assign advance   = !skid_full;
   assign req_stall = skid_full;

   dm64_pre u_pre (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .out_cell    (stage[0])
   );

   for (genvar k = 0; k < dm64_pkg::DATA_W; k++) begin : g_cell
      dm64_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .in_cell  (stage[k]),
         .out_cell (stage[k+1])
      );
   end

   dm64_out u_out (
      .clock       (clock),
      .reset       (reset),
      .last_cell   (stage[dm64_pkg::DATA_W]),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .skid_full   (skid_full)
   );

endmodule
